@@ rtl/bfiq_pkg.sv @@
// Shared types and constants of the bloom filter insert/query unit.
package bfiq_pkg;

    localparam int HASH_W       = 32;
    localparam int CNT_W        = $clog2(HASH_W + 1);
    localparam int NUM_BITS_W   = 17;
    localparam int NUM_HASHES_W = 5;
    localparam int CFG_DATA_W   = 17;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [HASH_W-1:0] SEED_FIRST  = 32'h9747_b28c;
    localparam logic [HASH_W-1:0] SEED_SECOND = 32'hc4ce_b9fe;
    localparam logic [HASH_W-1:0] MUL_FIRST   = 32'h5bd1_e995;
    localparam logic [HASH_W-1:0] MUL_SECOND  = 32'h27d4_eb2f;
    localparam int                MIX_SHIFT   = 15;

    localparam logic [NUM_BITS_W-1:0]   NUM_BITS_RESET   = 17'h1_0000;
    localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RESET = 5'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_HASHES = 2'd1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX,
        ST_MOD_FIRST,
        ST_MOD_SECOND,
        ST_PROBE,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/bfiq_ram.sv @@
// Generic single-port RAM with registered read data.
module bfiq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bfiq_mod_unit.sv @@
// Bit-serial remainder unit: 32-bit hash modulo the filter size.
module bfiq_mod_unit #(
    parameter int BW = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bfiq_pkg::HASH_W-1:0] dividend,
    input  logic [BW-1:0]               divisor,
    output logic                        done,
    output logic [BW-1:0]               rem
);

    logic [bfiq_pkg::CNT_W-1:0]  cnt_reg;
    logic [bfiq_pkg::CNT_W-1:0]  cnt_next;
    logic                        done_reg;
    logic                        done_next;
    logic [bfiq_pkg::HASH_W-1:0] dvd_reg;
    logic [bfiq_pkg::HASH_W-1:0] dvd_next;
    logic [BW-1:0]               rem_reg;
    logic [BW-1:0]               rem_next;
    logic [BW:0]                 trial;
    logic [BW:0]                 diff;

    assign trial = {rem_reg, dvd_reg[bfiq_pkg::HASH_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = bfiq_pkg::CNT_W'(bfiq_pkg::HASH_W);
            dvd_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == bfiq_pkg::CNT_W'(1));
            dvd_next  = {dvd_reg[bfiq_pkg::HASH_W-2:0], 1'b0};
            rem_next  = (trial >= {1'b0, divisor}) ? diff[BW-1:0] : trial[BW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/bloom_filter_insert_query_unit.sv @@
// Top level of the bloom filter insert/query unit.
//
// Input channel: one key byte per word (op, key_byte, last_byte) on
// in_valid/in_stall. Output channel: one word per finished key
// (was_query, maybe_present) on out_valid/out_stall. Configuration:
// cfg_we/cfg_index/cfg_data write num_bits (index 0) or num_hashes
// (index 1); other indexes are ignored.
// Each key byte goes through the two 32x32 hash multiplies, then the
// xor-shift mix. After its mix, the last byte goes on through two
// bit-serial remainder passes (hash modulo num_bits) in the shared
// remainder unit, one filter memory access per probe, and the posting
// of the result word.
// The block takes one word at a time; in_stall is high while a word is
// in work. A finished result sits in the output register until taken;
// the next key byte is accepted meanwhile, and a following result waits
// while out_stall holds the earlier one.
// After reset all MAX_BITS bits of the filter memory are swept to zero,
// one bit per cycle; input stays stalled during the sweep while
// configuration writes are taken. Hashes reseed after every key.
module bloom_filter_insert_query_unit #(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [7:0]                       key_byte,
    input  logic                             last_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             was_query,
    output logic                             maybe_present,
    input  logic                             cfg_we,
    input  logic [bfiq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bfiq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_BITS);
    localparam int BW = $clog2(MAX_BITS + 1);
    localparam int KW = $clog2(MAX_HASHES + 1);
    localparam int HW = bfiq_pkg::HASH_W;

    bfiq_pkg::state_t state_reg;
    bfiq_pkg::state_t state_next;

    logic [bfiq_pkg::NUM_BITS_W-1:0]   num_bits_reg;
    logic [bfiq_pkg::NUM_HASHES_W-1:0] num_hashes_reg;

    logic [HW-1:0] h1_reg;
    logic [HW-1:0] h1_next;
    logic [HW-1:0] h2_reg;
    logic [HW-1:0] h2_next;
    logic [HW-1:0] prod1_reg;
    logic [HW-1:0] prod1_next;
    logic [HW-1:0] prod2_reg;
    logic [HW-1:0] prod2_next;
    logic          op_reg;
    logic          last_reg;

    logic [BW-1:0] m_reg;
    logic [BW-1:0] m_next;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] k_next;
    logic [31:0]   m_full;
    logic [31:0]   k_full;

    logic [BW-1:0] a_reg;
    logic [BW-1:0] b_reg;
    logic [BW-1:0] pos_reg;
    logic [BW-1:0] pos_next;
    logic [BW:0]   pos_sum;
    logic [BW:0]   pos_wrap;
    logic [KW-1:0] cnt_reg;
    logic [KW-1:0] cnt_next;
    logic          probe_last;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] clr_next;

    logic          rd_pend_reg;
    logic          all_set_reg;
    logic          all_set_next;
    logic          all_set_now;
    logic          mod_start_reg;
    logic          mod_start_next;
    logic          mod_done;
    logic [BW-1:0] mod_rem;
    logic [HW-1:0] mod_dividend;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic          was_query_reg;
    logic          maybe_present_reg;
    logic          out_load;

    logic          in_accept;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic          ram_wdata;
    logic          ram_rdata;

    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == bfiq_pkg::ST_FINISH) && (!out_valid_reg || !out_stall);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bits_reg   <= bfiq_pkg::NUM_BITS_RESET;
            num_hashes_reg <= bfiq_pkg::NUM_HASHES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bfiq_pkg::CFG_NUM_BITS:
                begin
                    num_bits_reg <= cfg_data[bfiq_pkg::NUM_BITS_W-1:0];
                end
                bfiq_pkg::CFG_NUM_HASHES:
                begin
                    num_hashes_reg <= cfg_data[bfiq_pkg::NUM_HASHES_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // clamp config into the usable range
    always_comb
    begin
        m_full = 32'(num_bits_reg);
        if (m_full == 32'd0)
        begin
            m_full = 32'd1;
        end
        else if (m_full > 32'(MAX_BITS))
        begin
            m_full = 32'(MAX_BITS);
        end
        k_full = 32'(num_hashes_reg);
        if (k_full == 32'd0)
        begin
            k_full = 32'd1;
        end
        else if (k_full > 32'(MAX_HASHES))
        begin
            k_full = 32'(MAX_HASHES);
        end
    end

    assign pos_sum    = {1'b0, pos_reg} + {1'b0, b_reg};
    assign pos_wrap   = pos_sum - {1'b0, m_reg};
    assign probe_last = ((KW + 1)'(cnt_reg) + 1'b1) == {1'b0, k_reg};
    assign all_set_now = all_set_reg && (!rd_pend_reg || ram_rdata);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfiq_pkg::ST_CLEAR:
            begin
                if (clr_reg == AW'(MAX_BITS - 1))
                begin
                    state_next = bfiq_pkg::ST_IDLE;
                end
            end
            bfiq_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = bfiq_pkg::ST_MIX;
                end
            end
            bfiq_pkg::ST_MIX:
            begin
                state_next = last_reg ? bfiq_pkg::ST_MOD_FIRST : bfiq_pkg::ST_IDLE;
            end
            bfiq_pkg::ST_MOD_FIRST:
            begin
                if (mod_done)
                begin
                    state_next = bfiq_pkg::ST_MOD_SECOND;
                end
            end
            bfiq_pkg::ST_MOD_SECOND:
            begin
                if (mod_done)
                begin
                    state_next = bfiq_pkg::ST_PROBE;
                end
            end
            bfiq_pkg::ST_PROBE:
            begin
                if (probe_last)
                begin
                    state_next = bfiq_pkg::ST_FINISH;
                end
            end
            bfiq_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = bfiq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfiq_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall  = 1'b1;
        ram_we    = 1'b0;
        ram_addr  = pos_reg[AW-1:0];
        ram_wdata = 1'b1;
        case (state_reg)
            bfiq_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = 1'b0;
            end
            bfiq_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            bfiq_pkg::ST_PROBE:
            begin
                ram_we = (op_reg == bfiq_pkg::OP_INSERT);
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        prod1_next     = prod1_reg;
        prod2_next     = prod2_reg;
        m_next         = m_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        all_set_next   = all_set_now;
        mod_start_next = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        mod_dividend   = (state_reg == bfiq_pkg::ST_MOD_SECOND) ? h2_reg : h1_reg;
        case (state_reg)
            bfiq_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
            end
            bfiq_pkg::ST_IDLE:
            begin
                prod1_next = (h1_reg ^ HW'(key_byte)) * bfiq_pkg::MUL_FIRST;
                prod2_next = (h2_reg ^ HW'(key_byte)) * bfiq_pkg::MUL_SECOND;
            end
            bfiq_pkg::ST_MIX:
            begin
                h1_next        = prod1_reg ^ (prod1_reg >> bfiq_pkg::MIX_SHIFT);
                h2_next        = prod2_reg ^ (prod2_reg >> bfiq_pkg::MIX_SHIFT);
                m_next         = BW'(m_full);
                k_next         = KW'(k_full);
                mod_start_next = last_reg;
            end
            bfiq_pkg::ST_MOD_FIRST:
            begin
                mod_start_next = mod_done;
            end
            bfiq_pkg::ST_MOD_SECOND:
            begin
                pos_next     = a_reg;
                cnt_next     = '0;
                all_set_next = 1'b1;
            end
            bfiq_pkg::ST_PROBE:
            begin
                pos_next = (pos_sum >= {1'b0, m_reg}) ? pos_wrap[BW-1:0] : pos_sum[BW-1:0];
                cnt_next = cnt_reg + 1'b1;
            end
            bfiq_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    h1_next        = bfiq_pkg::SEED_FIRST;
                    h2_next        = bfiq_pkg::SEED_SECOND;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfiq_pkg::ST_CLEAR;
            clr_reg       <= '0;
            h1_reg        <= bfiq_pkg::SEED_FIRST;
            h2_reg        <= bfiq_pkg::SEED_SECOND;
            mod_start_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            h1_reg        <= h1_next;
            h2_reg        <= h2_next;
            mod_start_reg <= mod_start_next;
            rd_pend_reg   <= (state_reg == bfiq_pkg::ST_PROBE) && (op_reg == bfiq_pkg::OP_QUERY);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg   <= prod1_next;
        prod2_reg   <= prod2_next;
        m_reg       <= m_next;
        k_reg       <= k_next;
        pos_reg     <= pos_next;
        cnt_reg     <= cnt_next;
        all_set_reg <= all_set_next;
        if (in_accept)
        begin
            op_reg   <= op;
            last_reg <= last_byte;
        end
        if (mod_done && (state_reg == bfiq_pkg::ST_MOD_FIRST))
        begin
            a_reg <= mod_rem;
        end
        if (mod_done && (state_reg == bfiq_pkg::ST_MOD_SECOND))
        begin
            b_reg <= mod_rem;
        end
        if (out_load)
        begin
            was_query_reg     <= op_reg;
            maybe_present_reg <= (op_reg == bfiq_pkg::OP_QUERY) && all_set_now;
        end
    end

    bfiq_mod_unit #(
        .BW (BW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start_reg),
        .dividend (mod_dividend),
        .divisor  (m_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    bfiq_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BITS)
    ) u_filter_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign was_query     = was_query_reg;
    assign maybe_present = maybe_present_reg;

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == bfiq_pkg::ST_FINISH)
        else $error("result word posted outside finish");

    a_insert_not_present: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(maybe_present_reg && !was_query_reg))
        else $error("insert reported as present");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bfiq_pkg::ST_PROBE |-> pos_reg < m_reg)
        else $error("probe position beyond filter size");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> mod_rem < m_reg)
        else $error("remainder not below filter size");

    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfiq_pkg::ST_PROBE && op_reg == bfiq_pkg::OP_QUERY) |-> !ram_we)
        else $error("query wrote the filter memory");

endmodule
